// ----- src/splg_pkg.sv -----
`default_nettype none
package splg_pkg;

	// Pan-law selector codes
	typedef enum logic [2:0] {
		RULE_BAL    = 3'd0,
		RULE_LIN    = 3'd1,
		RULE_SIN3   = 3'd2,
		RULE_SIN45  = 3'd3,
		RULE_SIN6   = 3'd4,
		RULE_SQRT3  = 3'd5,
		RULE_SQRT45 = 3'd6,
		RULE_BAL7   = 3'd7
	} pan_rule_t;

	// Q30 odd Taylor coefficients of sin(pi/2 x), lowest degree first
	localparam int unsigned SIN_TERMS = 6;
	typedef logic [30:0] q30_t;
	localparam q30_t SIN_COEF [SIN_TERMS] = '{
		31'd1686629713, 31'd693598669, 31'd85569306,
		31'd5026995, 31'd172272, 31'd3864
	};

	// Boosts in Q30
	localparam q30_t BOOST_SQRT2 = 31'd1518500250;
	localparam q30_t BOOST_2P075 = 31'd1805811301;
	localparam q30_t Q30_ONE     = 31'h4000_0000;
	localparam q30_t Q30_HALF    = 31'h2000_0000;

	// Square-root operand width (holds a Q30 value shifted up by 30)
	localparam int unsigned SQ_NW = 62;

endpackage
`default_nettype wire

// ----- src/splg_isqrt.sv -----
`default_nettype none
module splg_isqrt #(
	parameter int unsigned NW = 62,
	parameter int unsigned SW = 8
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              adv,
	input  wire logic              in_v,
	input  wire logic [NW-1:0]     in_n,
	input  wire logic [SW-1:0]     in_side,
	output logic                   out_v,
	output logic [NW/2-1:0]        out_r,
	output logic [SW-1:0]          out_side
);
	localparam int unsigned D = NW / 2;

	logic          v_s    [D+1];
	logic [NW-1:0] n_s    [D+1];
	logic [NW-1:0] r_s    [D+1];
	logic [SW-1:0] side_s [D+1];

	assign v_s[0]    = in_v;
	assign n_s[0]    = in_n;
	assign r_s[0]    = '0;
	assign side_s[0] = in_side;

	// One result bit per stage, restoring digit-by-digit root
	for (genvar i = 0; i < D; i++) begin : g_stage
		localparam logic [NW-1:0] BIT = NW'(1) << (NW - 2 - 2 * i);
		logic [NW-1:0] sum;
		logic          ge;
		logic [NW-1:0] n_nx;
		logic [NW-1:0] r_nx;

		always_comb begin
			sum  = r_s[i] + BIT;
			ge   = n_s[i] >= sum;
			n_nx = ge ? n_s[i] - sum : n_s[i];
			r_nx = ge ? (r_s[i] >> 1) + BIT : r_s[i] >> 1;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (adv) begin
				v_s[i+1] <= v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				n_s[i+1]    <= n_nx;
				r_s[i+1]    <= r_nx;
				side_s[i+1] <= side_s[i];
			end
		end
	end

	assign out_v    = v_s[D];
	assign out_r    = r_s[D][D-1:0];
	assign out_side = side_s[D];

endmodule
`default_nettype wire

// ----- src/splg_chan.sv -----
`default_nettype none
module splg_chan
	import splg_pkg::*;
#(
	parameter int unsigned GAIN_FRAC_BITS = 14
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        adv,
	input  wire logic        in_v,
	input  wire logic [16:0] in_q,
	input  wire pan_rule_t   in_rule,
	output logic             out_v,
	output logic [15:0]      out_gain
);
	localparam int unsigned HN  = SIN_TERMS - 1;
	localparam int unsigned SW1 = 3 + 17 + 31;
	localparam int unsigned SW2 = 3 + 17 + 31 + 31;
	localparam int unsigned RW  = 34;

	// Square the argument: t = x*x in Q30 equals q*q
	logic        v_s1;
	logic [16:0] q_s1;
	logic [30:0] t_s1;
	pan_rule_t   rule_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_v;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			q_s1    <= in_q;
			t_s1    <= 31'(in_q) * 31'(in_q);
			rule_s1 <= in_rule;
		end
	end

	// Horner steps of the sine polynomial, one multiply per stage
	logic        hv_s    [HN+1];
	logic [16:0] hq_s    [HN+1];
	logic [30:0] ht_s    [HN+1];
	logic [30:0] hr_s    [HN+1];
	pan_rule_t   hrule_s [HN+1];

	assign hv_s[0]    = v_s1;
	assign hq_s[0]    = q_s1;
	assign ht_s[0]    = t_s1;
	assign hr_s[0]    = SIN_COEF[HN];
	assign hrule_s[0] = rule_s1;

	for (genvar j = 0; j < HN; j++) begin : g_horner
		logic [61:0] prod;
		logic [30:0] r_nx;

		always_comb begin
			prod = 62'(hr_s[j]) * 62'(ht_s[j]);
			r_nx = 31'(32'(SIN_COEF[HN-1-j]) - 32'(prod >> 30));
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				hv_s[j+1] <= 1'b0;
			end else if (adv) begin
				hv_s[j+1] <= hv_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				hq_s[j+1]    <= hq_s[j];
				ht_s[j+1]    <= ht_s[j];
				hr_s[j+1]    <= r_nx;
				hrule_s[j+1] <= hrule_s[j];
			end
		end
	end

	// Final multiply by x and clamp to 1.0
	logic        v_s7;
	logic [16:0] q_s7;
	logic [30:0] sn_s7;
	pan_rule_t   rule_s7;
	logic [47:0] sx;
	logic [32:0] sx_sh;

	always_comb begin
		sx    = 48'(hr_s[HN]) * 48'(hq_s[HN]);
		sx_sh = 33'(sx >> 15);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else if (adv) begin
			v_s7 <= hv_s[HN];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			q_s7    <= hq_s[HN];
			sn_s7   <= (sx_sh > 33'(Q30_ONE)) ? Q30_ONE : sx_sh[30:0];
			rule_s7 <= hrule_s[HN];
		end
	end

	// Square root of the argument: isqrt(x << 30) = isqrt(q << 45)
	logic             sq1_v;
	logic [30:0]      sq1_r;
	logic [SW1-1:0]   sq1_side;

	splg_isqrt #(.NW(SQ_NW), .SW(SW1)) u_sqrt_x (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_v     (v_s7),
		.in_n     (SQ_NW'(q_s7) << 45),
		.in_side  ({rule_s7, q_s7, sn_s7}),
		.out_v    (sq1_v),
		.out_r    (sq1_r),
		.out_side (sq1_side)
	);

	// Pick the operand of the 1.5 power and take its square root
	pan_rule_t   a_rule;
	logic [16:0] a_q;
	logic [30:0] a_sn;
	logic [30:0] a_v;

	always_comb begin
		a_rule = pan_rule_t'(sq1_side[SW1-1 -: 3]);
		a_q    = sq1_side[47:31];
		a_sn   = sq1_side[30:0];
		a_v    = (a_rule == RULE_SIN45) ? a_sn : sq1_r;
	end

	logic             sq2_v;
	logic [30:0]      sq2_r;
	logic [SW2-1:0]   sq2_side;

	splg_isqrt #(.NW(SQ_NW), .SW(SW2)) u_sqrt_v (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_v     (sq1_v),
		.in_n     (SQ_NW'(a_v) << 30),
		.in_side  ({a_rule, a_q, a_sn, sq1_r}),
		.out_v    (sq2_v),
		.out_r    (sq2_r),
		.out_side (sq2_side)
	);

	// Form v^1.5 = v * sqrt(v) in Q30
	pan_rule_t   b_rule;
	logic [16:0] b_q;
	logic [30:0] b_sn;
	logic [30:0] b_sq;
	logic [30:0] b_v;
	logic [61:0] b_prod;

	always_comb begin
		b_rule = pan_rule_t'(sq2_side[SW2-1 -: 3]);
		b_q    = sq2_side[78:62];
		b_sn   = sq2_side[61:31];
		b_sq   = sq2_side[30:0];
		b_v    = (b_rule == RULE_SIN45) ? b_sn : b_sq;
		b_prod = 62'(b_v) * 62'(sq2_r);
	end

	logic        v_m1;
	pan_rule_t   rule_m1;
	logic [16:0] q_m1;
	logic [30:0] sn_m1;
	logic [30:0] sq_m1;
	logic [30:0] p15_m1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_m1 <= 1'b0;
		end else if (adv) begin
			v_m1 <= sq2_v;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rule_m1 <= b_rule;
			q_m1    <= b_q;
			sn_m1   <= b_sn;
			sq_m1   <= b_sq;
			p15_m1  <= 31'(b_prod >> 30);
		end
	end

	// Apply the boost of the selected law
	logic [30:0] opa;
	logic [30:0] opb;
	logic [61:0] gprod;
	logic [32:0] pm;
	logic [32:0] g_nx;

	always_comb begin
		opa = sn_m1;
		opb = BOOST_SQRT2;
		g_nx = '0;
		unique case (rule_m1)
			RULE_SIN3:   begin opa = sn_m1;  opb = BOOST_SQRT2; end
			RULE_SIN45:  begin opa = p15_m1; opb = BOOST_2P075; end
			RULE_SIN6:   begin opa = sn_m1;  opb = sn_m1;       end
			RULE_SQRT3:  begin opa = sq_m1;  opb = BOOST_SQRT2; end
			RULE_SQRT45: begin opa = p15_m1; opb = BOOST_2P075; end
			RULE_LIN, RULE_BAL, RULE_BAL7: begin opa = sn_m1; opb = BOOST_SQRT2; end
		endcase
		gprod = 62'(opa) * 62'(opb);
		pm    = 33'(gprod >> 30);
		unique case (rule_m1)
			RULE_LIN:  g_nx = 33'(q_m1) << 16;
			RULE_SIN6: g_nx = pm << 1;
			RULE_SIN3, RULE_SIN45, RULE_SQRT3, RULE_SQRT45: g_nx = pm;
			RULE_BAL, RULE_BAL7: begin
				g_nx = ((33'(q_m1) << 15) < 33'(Q30_HALF)) ? (33'(q_m1) << 16)
					: (33'(Q30_HALF) << 1);
			end
		endcase
	end

	logic        v_m2;
	logic [32:0] g_m2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_m2 <= 1'b0;
		end else if (adv) begin
			v_m2 <= v_m1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			g_m2 <= g_nx;
		end
	end

	// Round half up to the output format and saturate at 2.0
	localparam logic [RW-1:0] RND_HALF = RW'(1) << (29 - GAIN_FRAC_BITS);
	localparam logic [RW-1:0] LIM      = RW'(2) << GAIN_FRAC_BITS;
	logic [RW-1:0] rnd;
	logic [RW-1:0] sat;

	always_comb begin
		rnd = (RW'(g_m2) + RND_HALF) >> (30 - GAIN_FRAC_BITS);
		sat = (rnd > LIM) ? LIM : rnd;
	end

	logic        v_m3;
	logic [15:0] gain_m3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_m3 <= 1'b0;
		end else if (adv) begin
			v_m3 <= v_m2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			gain_m3 <= sat[15:0];
		end
	end

	assign out_v    = v_m3;
	assign out_gain = gain_m3;

endmodule
`default_nettype wire

// ----- src/stereo_pan_law_gain_unit.sv -----
// Channel   Signals                      Payload
// s_axis    s_tvalid s_tready s_tdata    pan_position (16b signed)
// m_axis    m_tvalid m_tready m_tdata    left_gain, right_gain (16b each)
// cfg       cfg_valid cfg_ready cfg_data pan_rule (3b), always ready
//
// One item per cycle sustained while m_tready stays high; most of the
// pipeline depth lies in each channel's two 31-stage square-root pipelines.
// arst_n clears all valid bits and pan_rule; the output data is not reset.
// A stall on m_tready fills a one-item skid register first; the whole
// pipeline then holds, so no item is dropped or repeated.
`default_nettype none
module stereo_pan_law_gain_unit
	import splg_pkg::*;
#(
	parameter int unsigned GAIN_FRAC_BITS = 14
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,   // [15:0] pan_position
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,   // [15:0] left_gain, [31:16] right_gain
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_data
);
	pan_rule_t rule_q;
	logic      adv;
	logic      skid_v_q;
	logic [31:0] skid_d_q;
	logic      out_v_q;
	logic [31:0] out_d_q;

	assign adv       = !skid_v_q;
	assign s_tready  = adv;
	assign cfg_ready = 1'b1;

	// Hold the pan law register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rule_q <= RULE_BAL;
		end else if (cfg_valid && cfg_ready) begin
			rule_q <= pan_rule_t'(cfg_data);
		end
	end

	// Clamp the pan and offset it to 0..32768
	logic signed [16:0] pan_x;
	logic [16:0]        u_nx;

	always_comb begin
		pan_x = 17'(signed'(s_tdata));
		if (pan_x < -17'sd16384) begin
			u_nx = 17'd0;
		end else if (pan_x > 17'sd16384) begin
			u_nx = 17'd32768;
		end else begin
			u_nx = 17'(pan_x + 17'sd16384);
		end
	end

	logic        v_s1;
	logic [16:0] u_s1;
	pan_rule_t   rule_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			u_s1    <= u_nx;
			rule_s1 <= rule_q;
		end
	end

	// Left and right gain datapaths
	logic        lv, rv;
	logic [15:0] lg, rg;

	splg_chan #(.GAIN_FRAC_BITS(GAIN_FRAC_BITS)) u_left (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_v     (v_s1),
		.in_q     (17'd32768 - u_s1),
		.in_rule  (rule_s1),
		.out_v    (lv),
		.out_gain (lg)
	);

	splg_chan #(.GAIN_FRAC_BITS(GAIN_FRAC_BITS)) u_right (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_v     (v_s1),
		.in_q     (u_s1),
		.in_rule  (rule_s1),
		.out_v    (rv),
		.out_gain (rg)
	);

	// Output register with a one-item skid
	logic take;
	assign take = lv && rv && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (m_tready) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end
		end else if (!out_v_q || m_tready) begin
			out_v_q <= take;
		end else if (take) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (m_tready) begin
				out_d_q <= skid_d_q;
			end
		end else if (!out_v_q || m_tready) begin
			out_d_q <= {rg, lg};
		end else if (take) begin
			skid_d_q <= {rg, lg};
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = out_d_q;

	// Checks
	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q) else $error("skid holds an item with no output item");
	a_skid_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_v_q) |-> $past(out_v_q && !m_tready))
		else $error("skid filled without an output stall");
	a_lanes_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		lv == rv) else $error("left and right lanes out of step");
	a_gain_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && GAIN_FRAC_BITS <= 14) |->
		(32'(m_tdata[15:0]) <= (32'd2 << GAIN_FRAC_BITS) &&
		 32'(m_tdata[31:16]) <= (32'd2 << GAIN_FRAC_BITS)))
		else $error("gain above saturation limit");

endmodule
`default_nettype wire

// ----- tb/sv/stereo_pan_law_gain_unit_tb.sv -----
`timescale 1ns / 100ps
`default_nettype none
module stereo_pan_law_gain_unit_tb;
	import splg_pkg::*;

	localparam int FRAC = 14;
	localparam int LATENCY = 74;
	localparam int STALL_LIMIT = 5000;

	// Q30 math helpers for the gain predictor
	function automatic logic [63:0] isqrt(input logic [63:0] n);
		logic [63:0] res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > n)
			bitv = bitv >> 2;
		while (bitv != 0) begin
			if (n >= res + bitv) begin
				n = n - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	function automatic logic [63:0] root_q30(input logic [63:0] v);
		return isqrt(v << 30);
	endfunction

	function automatic logic [63:0] pow_three_halves(input logic [63:0] v);
		return (v * root_q30(v)) >> 30;
	endfunction

	function automatic logic [63:0] quarter_sine(input logic [63:0] x);
		logic [63:0] t, r;
		logic [63:0] c [6];
		c = '{64'd1686629713, 64'd693598669, 64'd85569306, 64'd5026995, 64'd172272,
			64'd3864};
		t = (x * x) >> 30;
		r = c[5];
		for (int k = 4; k >= 0; k--)
			r = c[k] - ((r * t) >> 30);
		r = (r * x) >> 30;
		return (r > (64'd1 << 30)) ? (64'd1 << 30) : r;
	endfunction

	function automatic logic [63:0] boosted_gain(input pan_rule_t rule, input logic [63:0] x);
		logic [63:0] s;
		case (rule)
			RULE_LIN:    return x << 1;
			RULE_SIN3:   return (quarter_sine(x) * 64'd1518500250) >> 30;
			RULE_SIN45:  return (pow_three_halves(quarter_sine(x)) * 64'd1805811301) >> 30;
			RULE_SIN6: begin
				s = quarter_sine(x);
				return ((s * s) >> 30) << 1;
			end
			RULE_SQRT3:  return (root_q30(x) * 64'd1518500250) >> 30;
			RULE_SQRT45: return (pow_three_halves(root_q30(x)) * 64'd1805811301) >> 30;
			default: begin
				s = (x < (64'd1 << 29)) ? x : (64'd1 << 29);
				return s << 1;
			end
		endcase
	endfunction

	function automatic logic [15:0] round_gain(input logic [63:0] g);
		logic [63:0] r;
		r = (g + (64'd1 << (29 - FRAC))) >> (30 - FRAC);
		if (r > (64'd2 << FRAC))
			r = 64'd2 << FRAC;
		return r[15:0];
	endfunction

	// Expected gain pairs, oldest first
	class gain_scoreboard;
		logic [31:0] pending_gains [$];
		pan_rule_t rule;
		int errors;

		function void note_pan(input logic [15:0] pan_raw);
			int pan;
			logic [63:0] u;
			logic [15:0] lg, rg;
			pan = $signed(pan_raw);
			if (pan < -16384)
				pan = -16384;
			if (pan > 16384)
				pan = 16384;
			u = pan + 16384;
			lg = round_gain(boosted_gain(rule, (64'd32768 - u) << 15));
			rg = round_gain(boosted_gain(rule, u << 15));
			pending_gains.push_back({rg, lg});
		endfunction

		function void check_gains(input logic [31:0] got);
			logic [31:0] want;
			if (pending_gains.size() == 0) begin
				$display("%0t: unexpected item, expected none, actual %h", $time, got);
				errors++;
				return;
			end
			want = pending_gains.pop_front();
			if (got[15:0] !== want[15:0]) begin
				$display("%0t: left_gain expected %0d actual %0d", $time, want[15:0], got[15:0]);
				errors++;
			end
			if (got[31:16] !== want[31:16]) begin
				$display("%0t: right_gain expected %0d actual %0d", $time, want[31:16],
					got[31:16]);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [15:0] s_tdata = 0;
	logic m_tvalid;
	logic m_tready = 0;
	logic [31:0] m_tdata;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [2:0] cfg_data = 0;

	gain_scoreboard gains = new();
	int idle_cycles = 0;
	int stall_mode = 0;
	int stall_phase = 0;

	stereo_pan_law_gain_unit u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// Check results; stall on a rotating pattern; watch for a hang
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				gains.check_gains(m_tdata);
			if ((m_tvalid && m_tready) || (s_tvalid && s_tready) || (cfg_valid && cfg_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles > STALL_LIMIT) begin
				$display("stereo_pan_law_gain_unit: mismatch");
				$finish;
			end
			stall_phase <= stall_phase + 1;
			case (stall_mode)
				0: m_tready <= 1'b1;
				1: m_tready <= (stall_phase % 4) != 3;
				2: m_tready <= (stall_phase % 7) < 2;
				default: m_tready <= 1'($urandom_range(0, 1));
			endcase
		end
	end

	task automatic write_rule(input pan_rule_t rule);
		cfg_valid <= 1'b1;
		cfg_data <= rule;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		gains.rule = rule;
	endtask

	task automatic send_pan(input logic [15:0] pan);
		s_tvalid <= 1'b1;
		s_tdata <= pan;
		do @(posedge clk); while (!s_tready);
		gains.note_pan(pan);
	endtask

	// Random burst of pans with a gap after it
	task automatic send_burst(input int count);
		logic [15:0] pan;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 9) == 0)
				pan = 16'($urandom);
			else
				pan = 16'($signed($urandom_range(0, 32768)) - 16384);
			send_pan(pan);
		end
		s_tvalid <= 1'b0;
		repeat ($urandom_range(1, 4)) @(posedge clk);
	endtask

	task automatic drain;
		while (gains.pending_gains.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	initial begin
		logic [15:0] corner [10];
		pan_rule_t order [10];
		corner = '{16'h0000, 16'hC000, 16'h4000, 16'h8000, 16'h7FFF, 16'hBFFF,
			16'h4001, 16'hFFFF, 16'h0001, 16'hE000};
		order = '{RULE_BAL, RULE_LIN, RULE_SIN3, RULE_SIN45, RULE_SIN6, RULE_SQRT3,
			RULE_SQRT45, RULE_BAL7, RULE_SQRT45, RULE_BAL};
		gains.rule = RULE_BAL;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: ends, centre, out-of-range pans under reset rule, then all rules
		foreach (corner[i])
			send_pan(corner[i]);
		s_tvalid <= 1'b0;
		drain();
		for (int r = 1; r < 8; r++) begin
			write_rule(pan_rule_t'(r));
			send_pan(16'hC000);
			send_pan(16'h0000);
			send_pan(16'h4000);
			s_tvalid <= 1'b0;
			drain();
		end

		// Random phases, one per rule setting and stall pattern
		foreach (order[p]) begin
			write_rule(order[p]);
			stall_mode <= p % 4;
			for (int n = 0; n < 60;) begin
				int len;
				len = $urandom_range(1, 12);
				send_burst(len);
				n += len;
			end
			drain();
		end

		if (gains.errors == 0)
			$display("stereo_pan_law_gain_unit: match");
		else
			$display("stereo_pan_law_gain_unit: mismatch");
		$finish;
	end
endmodule
`default_nettype wire

// ----- stereo_pan_law_gain_unit.f -----
src/splg_pkg.sv
src/splg_isqrt.sv
src/splg_chan.sv
src/stereo_pan_law_gain_unit.sv
tb/sv/stereo_pan_law_gain_unit_tb.sv
